FILE: hdl/bcsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsd_pkg: shared types and constants of the bond stretch damage block
// Holds the sequencer states, the opcodes and the fixed field widths.
// ----------------------------------------------------------------------------
package bcsd_pkg;

	localparam int STRETCH_W   = 32;   // critical stretch, unsigned Q8.24
	localparam int FRAC_BITS   = 24;   // fraction bits of the stretch
	localparam int SLOT_W      = 12;   // bond slot field width
	localparam int PROD_W      = 64;   // shared multiplier product width
	localparam int MOD_CNT_W   = 4;    // step counter of the slot reduction

	localparam logic [STRETCH_W-1:0] STRETCH_RESET = 32'd8389;

	localparam logic OP_NODE = 1'b0;
	localparam logic OP_BOND = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQ,
		ST_RSTART,
		ST_ROOT,
		ST_MUL,
		ST_CMP,
		ST_OUT
	} bcsd_state_t;

endpackage

FILE: hdl/bcsd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsd_isqrt: iterative floor integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bcsd_isqrt #(
	parameter int ROOT_W = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [2*ROOT_W-1:0]  rad_q;
	logic [ROOT_W+1:0]    rem_q;
	logic [ROOT_W-1:0]    root_q;

	logic [ROOT_W+3:0]    shifted;
	logic [ROOT_W+3:0]    trial;
	logic                 fits;

	// Bring down the next two radicand bits and try the candidate 4*root+1.
	always_comb begin
		shifted = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		fits    = (shifted >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? (ROOT_W+2)'(shifted - trial) : (ROOT_W+2)'(shifted);
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/bond_critical_stretch_damage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bond_critical_stretch_damage: peridynamic bond failure by critical stretch
// Latches a centre node, then checks one bond per request against the
// critical stretch and keeps a sticky broken flag for every bond slot.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (critical stretch, Q8.24)
// in        in         in_valid / in_ready    opcode, ref_x/y/z, cur_x/y/z, bond_slot
// out       out        out_valid / out_ready  bond_broken, slot_out
//
// A node request (opcode 0) latches the centre node and produces no result.
// A bond request runs through the squaring on the shared multiplier, the start
// of the roots, the two bit-serial square roots that run side by side, and
// then the stretch product, the compare with the flag update and the result
// hand-off before the block is ready again.
// After reset the damage store is swept to zero, one slot per cycle, so
// in_ready stays low until the sweep is done; configuration writes are taken
// throughout. A stalled output holds the previous result in the output
// register while the block waits in its hand-off state with the new one.
//
module bond_critical_stretch_damage
	import bcsd_pkg::*;
#(
	parameter int MAX_BONDS  = 4096,
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [STRETCH_W-1:0]          cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic signed [COORD_BITS-1:0]  ref_x,
	input  logic signed [COORD_BITS-1:0]  ref_y,
	input  logic signed [COORD_BITS-1:0]  ref_z,
	input  logic signed [COORD_BITS-1:0]  cur_x,
	input  logic signed [COORD_BITS-1:0]  cur_y,
	input  logic signed [COORD_BITS-1:0]  cur_z,
	input  logic [SLOT_W-1:0]             bond_slot,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          bond_broken,
	output logic [SLOT_W-1:0]             slot_out
);

	// The lengths need one bit more than a coordinate: the largest distance
	// is below sqrt(3) times 2^COORD_BITS.
	localparam int ROOT_W = COORD_BITS + 1;
	localparam int SUM_W  = 2 * ROOT_W;
	localparam int IDX_W  = $clog2(MAX_BONDS);

	// The slot is reduced modulo MAX_BONDS by restoring subtraction of
	// shifted copies of MAX_BONDS, one per cycle. No steps are needed when
	// every slot value already fits the store.
	localparam int SLOT_RANGE = 2 ** SLOT_W;
	localparam int MOD_STEPS  = (MAX_BONDS >= SLOT_RANGE) ? 0 :
		$clog2((SLOT_RANGE + MAX_BONDS - 1) / MAX_BONDS);
	localparam logic [31:0] BONDS_32 = 32'(MAX_BONDS);

	bcsd_state_t state_q, state_d;

	// Configuration and latched centre node.
	logic [STRETCH_W-1:0]          stretch_q;
	logic signed [COORD_BITS-1:0]  cref_q [3];
	logic signed [COORD_BITS-1:0]  ccur_q [3];

	// Neighbor of the bond under evaluation.
	logic signed [COORD_BITS-1:0]  nref_q [3];
	logic signed [COORD_BITS-1:0]  ncur_q [3];
	logic [SLOT_W-1:0]             slot_q;

	// Sequencer bookkeeping.
	logic [2:0]                    step_q;
	logic [IDX_W-1:0]              clr_q;
	logic [SLOT_W-1:0]             mod_rem_q;
	logic [MOD_CNT_W-1:0]          mod_k_q;

	// Squaring datapath around the shared multiplier.
	logic signed [COORD_BITS-1:0]  pa, pb;
	logic signed [COORD_BITS:0]    dsum;
	logic [COORD_BITS:0]           dmag;
	logic [COORD_BITS-1:0]         absd_s1;
	logic [31:0]                   mul_a, mul_b;
	logic [PROD_W-1:0]             prod_s2;
	logic [SUM_W-1:0]              sum_ref_q, sum_cur_q;

	// Square roots and the decision.
	logic                          root_ref_done, root_cur_done;
	logic [ROOT_W-1:0]             len0, len1;
	logic [ROOT_W-1:0]             len_delta;
	logic [PROD_W-1:0]             growth;
	logic                          broken_d;
	logic                          res_broken_q;

	// Damage store.
	logic                          damage_mem [MAX_BONDS];
	logic [IDX_W-1:0]              idx;
	logic                          flag_s1;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_addr;
	logic                          mem_wdata;

	logic                          in_fire;
	logic                          root_start;
	logic                          out_load;
	logic [31:0]                   mod_sub;
	logic                          out_valid_q;
	logic                          bond_broken_q;
	logic [SLOT_W-1:0]             slot_out_q;

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_W'(MAX_BONDS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && opcode == OP_BOND) state_d = ST_SQ;
			end
			ST_SQ: begin
				if (step_q == 3'd7) state_d = ST_RSTART;
			end
			ST_RSTART: state_d = ST_ROOT;
			ST_ROOT: begin
				if (root_ref_done) state_d = ST_MUL;
			end
			ST_MUL:    state_d = ST_CMP;
			ST_CMP:    state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		root_start = 1'b0;
		out_load   = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = idx;
		mem_wdata  = broken_d;
		mul_a      = 32'(absd_s1);
		mul_b      = 32'(absd_s1);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = 1'b0;
			end
			ST_IDLE:   in_ready = 1'b1;
			ST_SQ:     ;
			ST_RSTART: root_start = 1'b1;
			ST_ROOT:   ;
			ST_MUL: begin
				mul_a = stretch_q;
				mul_b = 32'(len0);
			end
			ST_CMP:    mem_we = 1'b1;
			ST_OUT:    out_load = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			step_q  <= '0;
			mod_k_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (in_fire) begin
				step_q  <= '0;
				mod_k_q <= MOD_CNT_W'(MOD_STEPS);
			end else begin
				if (state_q == ST_SQ) step_q <= step_q + 1'b1;
				if (mod_k_q != '0) mod_k_q <= mod_k_q - 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration register and centre node
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stretch_q <= STRETCH_RESET;
			for (int i = 0; i < 3; i++) begin
				cref_q[i] <= '0;
				ccur_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) stretch_q <= cfg_data;
			if (in_fire && opcode == OP_NODE) begin
				cref_q[0] <= ref_x;
				cref_q[1] <= ref_y;
				cref_q[2] <= ref_z;
				ccur_q[0] <= cur_x;
				ccur_q[1] <= cur_y;
				ccur_q[2] <= cur_z;
			end
		end
	end

	// Bond operands are latched on every request; a node request leaves
	// them unused.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			nref_q[0] <= ref_x;
			nref_q[1] <= ref_y;
			nref_q[2] <= ref_z;
			ncur_q[0] <= cur_x;
			ncur_q[1] <= cur_y;
			ncur_q[2] <= cur_z;
			slot_q    <= bond_slot;
		end
	end

	// ------------------------------------------------------------------
	// Slot reduction, finished well before the roots are ready
	// ------------------------------------------------------------------
	assign mod_sub = BONDS_32 << (mod_k_q - 1'b1);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mod_rem_q <= bond_slot;
		end else if (mod_k_q != '0 && 32'(mod_rem_q) >= mod_sub) begin
			mod_rem_q <= mod_rem_q - SLOT_W'(mod_sub);
		end
	end

	// When the store is smaller than the slot range the reduced value is
	// below MAX_BONDS, so the cast only drops zero bits.
	assign idx = IDX_W'(mod_rem_q);

	// ------------------------------------------------------------------
	// Squared distances: difference, then square, then accumulate.
	// Steps 0 to 2 cover the reference axes, 3 to 5 the current ones.
	// ------------------------------------------------------------------
	always_comb begin
		case (step_q)
			3'd0:    begin pa = cref_q[0]; pb = nref_q[0]; end
			3'd1:    begin pa = cref_q[1]; pb = nref_q[1]; end
			3'd2:    begin pa = cref_q[2]; pb = nref_q[2]; end
			3'd3:    begin pa = ccur_q[0]; pb = ncur_q[0]; end
			3'd4:    begin pa = ccur_q[1]; pb = ncur_q[1]; end
			3'd5:    begin pa = ccur_q[2]; pb = ncur_q[2]; end
			default: begin pa = '0;        pb = '0;        end
		endcase
		dsum = (COORD_BITS+1)'(pa) - (COORD_BITS+1)'(pb);
		dmag = dsum[COORD_BITS] ? unsigned'(-dsum) : unsigned'(dsum);
	end

	always_ff @(posedge clk) begin
		absd_s1 <= dmag[COORD_BITS-1:0];
		prod_s2 <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sum_ref_q <= '0;
			sum_cur_q <= '0;
		end else if (state_q == ST_SQ) begin
			if (step_q >= 3'd2 && step_q <= 3'd4)
				sum_ref_q <= sum_ref_q + prod_s2[SUM_W-1:0];
			else if (step_q >= 3'd5)
				sum_cur_q <= sum_cur_q + prod_s2[SUM_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Two square roots in lockstep: initial and current bond length.
	// ------------------------------------------------------------------
	bcsd_isqrt #(
		.ROOT_W   (ROOT_W)
	) u_root_ref (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum_ref_q),
		.done     (root_ref_done),
		.root     (len0)
	);

	bcsd_isqrt #(
		.ROOT_W   (ROOT_W)
	) u_root_cur (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum_cur_q),
		.done     (root_cur_done),
		.root     (len1)
	);

	// ------------------------------------------------------------------
	// Failure test: (L - L0) * 2^24 > stretch * L0, with the stretch product
	// sitting in the multiplier register. A bond that already broke stays so.
	// ------------------------------------------------------------------
	always_comb begin
		len_delta = len1 - len0;
		growth    = PROD_W'(len_delta) << FRAC_BITS;
		broken_d  = flag_s1 || ((len1 > len0) && (growth > prod_s2));
	end

	// Damage store: one write port shared by the sweep and the update,
	// one registered read port at the reduced slot.
	always_ff @(posedge clk) begin
		if (mem_we) damage_mem[mem_addr] <= mem_wdata;
		flag_s1 <= damage_mem[idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) res_broken_q <= broken_d;
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bond_broken_q <= res_broken_q;
			slot_out_q    <= slot_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign bond_broken = bond_broken_q;
	assign slot_out    = slot_out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_bond_starts_squaring: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && opcode == OP_BOND) |=> (state_q == ST_SQ && step_q == 3'd0))
		else $error("bond request did not start the squaring sequence");

	a_roots_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		root_ref_done == root_cur_done)
		else $error("square root units fell out of step");

	a_slot_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		root_ref_done |-> (mod_k_q == '0))
		else $error("slot reduction unfinished when the lengths were ready");

	a_result_after_compare: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result presented outside the hand-off state");

	a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("request accepted during the damage store sweep");

endmodule
